/* rtl/serial_command_frame_handler_assert.svh */
// assertion macros for the serial command frame handler
`ifndef SERIAL_COMMAND_FRAME_HANDLER_ASSERT_SVH
`define SERIAL_COMMAND_FRAME_HANDLER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SFH_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sfh assertion failed");

// next-cycle implication, disabled in reset
`define SFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sfh assertion failed");

`endif

/* rtl/sfh_pkg.sv */
// types and constants of the serial command frame handler
`timescale 1ns / 1ps

package sfh_pkg;

  // frame bytes
  localparam logic [7:0] HDR1_BYTE  = 8'hFA;
  localparam logic [7:0] HDR2_BYTE  = 8'hAF;
  localparam logic [7:0] TAIL1_BYTE = 8'hFB;
  localparam logic [7:0] TAIL2_BYTE = 8'hBF;

  // response bytes
  localparam logic [7:0] RSP_HDR1_BYTE  = 8'hFC;
  localparam logic [7:0] RSP_HDR2_BYTE  = 8'hCF;
  localparam logic [7:0] RSP_LEN_BYTE   = 8'h03;
  localparam logic [7:0] RSP_TAIL1_BYTE = 8'hFD;
  localparam logic [7:0] RSP_TAIL2_BYTE = 8'hDF;
  localparam logic [7:0] RESULT_OK      = 8'h01;
  localparam logic [7:0] RESULT_FAIL    = 8'h00;

  // commands and data codes
  localparam logic [7:0] CMD_LED   = 8'h01;
  localparam logic [7:0] CMD_BLINK = 8'h02;
  localparam logic [7:0] DATA_OFF  = 8'h00;
  localparam logic [7:0] DATA_ON   = 8'h01;

  // response word positions
  localparam logic [2:0] RSP_POS_HDR1   = 3'd0;
  localparam logic [2:0] RSP_POS_HDR2   = 3'd1;
  localparam logic [2:0] RSP_POS_LEN    = 3'd2;
  localparam logic [2:0] RSP_POS_RESULT = 3'd3;
  localparam logic [2:0] RSP_POS_TAIL1  = 3'd4;
  localparam logic [2:0] RSP_POS_TAIL2  = 3'd5;

  typedef enum logic [2:0] {
    PH_HDR1  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_CMD   = 3'd2,
    PH_DATA  = 3'd3,
    PH_TAIL1 = 3'd4,
    PH_TAIL2 = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       running;
    logic       tx_idle;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       led_write;
    logic       led_on;
    logic       blink_start;
    logic [8:0] blink_toggles;
    logic       blink_stop;
    logic       last;
  } out_item_t;

  // pending action of one completed frame
  typedef struct packed {
    logic       tx_resp;
    logic       res_ok;
    logic       led_write;
    logic       led_on;
    logic       blink_start;
    logic [8:0] blink_toggles;
    logic       blink_stop;
  } action_t;

endpackage

/* rtl/sfh_if.sv */
// valid/ready stream interfaces of the serial command frame handler
`timescale 1ns / 1ps

interface sfh_in_if;
  import sfh_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfh_out_if;
  import sfh_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/serial_command_frame_handler.sv */
// Serial command frame handler: takes one received byte per cycle and parses
// frames FA AF cmd data FB BF. The parser state updates in the cycle a word is
// accepted, so a byte can be taken every cycle while the queue has room. A
// completed frame that does something is turned into an action and held in a
// two-entry action queue; if the queue was empty, its first word is offered in
// the cycle after the closing byte is accepted. The queue head drives the output:
// one word for an action without response, six words (FC CF 03 result FD DF) for
// a response, one per cycle while the receiver is ready, with the LED and blink
// fields on the first word and last on the final one. Input ready depends only on
// the queue fill and drops while both queue entries are occupied; every byte
// offered then waits until the head has drained its last word.
`timescale 1ns / 1ps

module serial_command_frame_handler (
  input logic     clk_i,
  input logic     rst_ni,
  sfh_in_if.sink    cmd_i,
  sfh_out_if.source rsp_o
);
  import sfh_pkg::*;

`include "serial_command_frame_handler_assert.svh"

  localparam logic [2:0] LAST_POS = RSP_POS_TAIL2;

  phase_e     phase_q, phase_d;
  logic [7:0] command_q, command_d;
  logic [7:0] data_q, data_d;

  action_t    queue_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic [2:0] pos_q;

  logic       accept;
  logic       take;
  logic [7:0] rx;
  logic       push;
  action_t    push_act;
  logic       pop;
  logic       out_fire;
  action_t    head;

  assign rx       = cmd_i.data.rx_byte;
  assign cmd_i.ready = (cnt_q != 2'd2);
  assign accept   = cmd_i.valid && cmd_i.ready;
  assign take     = accept && cmd_i.data.running;

  // parser next state
  always_comb begin
    phase_d   = phase_q;
    command_d = command_q;
    data_d    = data_q;
    if (take) begin
      case (phase_q)
        PH_HDR1: begin
          if (rx == HDR1_BYTE) phase_d = PH_HDR2;
        end
        PH_HDR2: begin
          phase_d = (rx == HDR2_BYTE) ? PH_CMD : PH_HDR1;
        end
        PH_CMD: begin
          command_d = rx;
          phase_d   = PH_DATA;
        end
        PH_DATA: begin
          data_d  = rx;
          phase_d = PH_TAIL1;
        end
        PH_TAIL1: begin
          phase_d = (rx == TAIL1_BYTE) ? PH_TAIL2 : PH_HDR1;
        end
        PH_TAIL2: begin
          phase_d = PH_HDR1;
        end
        default: begin
          phase_d = PH_HDR1;
        end
      endcase
    end
  end

  // action of a completed frame
  always_comb begin
    push     = 1'b0;
    push_act = '0;
    if (take && phase_q == PH_TAIL2 && rx == TAIL2_BYTE) begin
      case (command_q)
        CMD_LED: begin
          if (data_q == DATA_OFF || data_q == DATA_ON) begin
            push               = 1'b1;
            push_act.tx_resp   = cmd_i.data.tx_idle;
            push_act.res_ok    = 1'b1;
            push_act.led_write = 1'b1;
            push_act.led_on    = (data_q == DATA_ON);
          end else if (cmd_i.data.tx_idle) begin
            push             = 1'b1;
            push_act.tx_resp = 1'b1;
          end
        end
        CMD_BLINK: begin
          push = 1'b1;
          if (data_q == DATA_OFF) begin
            push_act.tx_resp    = cmd_i.data.tx_idle;
            push_act.res_ok     = 1'b1;
            push_act.blink_stop = 1'b1;
            push_act.led_write  = 1'b1;
          end else begin
            push_act.blink_start   = 1'b1;
            push_act.blink_toggles = {data_q, 1'b0};
          end
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR1;
      command_q <= '0;
      data_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      command_q <= command_d;
      data_q    <= data_d;
    end
  end

  // action queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= push_act;
    end
  end

  assign head     = queue_q[rd_ptr_q];
  assign out_fire = rsp_o.valid && rsp_o.ready;
  assign pop      = out_fire && rsp_o.data.last;

  // queue pointers, fill count and response position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
      pos_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        pos_q    <= '0;
      end else if (out_fire) begin
        pos_q <= pos_q + 3'd1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // output word from the queue head
  always_comb begin
    rsp_o.valid = (cnt_q != 2'd0);
    rsp_o.data  = '0;
    if (head.tx_resp) begin
      rsp_o.data.tx_valid = 1'b1;
      case (pos_q)
        RSP_POS_HDR1:   rsp_o.data.tx_byte = RSP_HDR1_BYTE;
        RSP_POS_HDR2:   rsp_o.data.tx_byte = RSP_HDR2_BYTE;
        RSP_POS_LEN:    rsp_o.data.tx_byte = RSP_LEN_BYTE;
        RSP_POS_RESULT: rsp_o.data.tx_byte = head.res_ok ? RESULT_OK : RESULT_FAIL;
        RSP_POS_TAIL1:  rsp_o.data.tx_byte = RSP_TAIL1_BYTE;
        RSP_POS_TAIL2:  rsp_o.data.tx_byte = RSP_TAIL2_BYTE;
        default:        rsp_o.data.tx_byte = '0;
      endcase
      rsp_o.data.last = (pos_q == LAST_POS);
    end else begin
      rsp_o.data.last = 1'b1;
    end
    // side-band fields only on the first word
    if (pos_q == RSP_POS_HDR1) begin
      rsp_o.data.led_write     = head.led_write;
      rsp_o.data.led_on        = head.led_on;
      rsp_o.data.blink_start   = head.blink_start;
      rsp_o.data.blink_toggles = head.blink_toggles;
      rsp_o.data.blink_stop    = head.blink_stop;
    end
  end

  // assertions
  `SFH_ASSERT_IMPLY(a_empty_pos_zero, clk_i, rst_ni, cnt_q == 2'd0, pos_q == 3'd0)
  `SFH_ASSERT_NEXT(a_pos_steps, clk_i, rst_ni, out_fire && !pop, pos_q == $past(pos_q) + 3'd1)
  `SFH_ASSERT_NEXT(a_cnt_grows, clk_i, rst_ni, push && !pop, cnt_q == $past(cnt_q) + 2'd1)

endmodule

/* bench/tb_serial_command_frame_handler.sv */
// testbench for the serial command frame handler: directed frames, back-pressure, random traffic
`timescale 1ns / 1ps

module tb_serial_command_frame_handler;
  import sfh_pkg::*;

  localparam int RANDOM_WORDS = 270;
  localparam int CALM_WORDS   = 80;
  localparam int HOLD_CYCLES  = 100;
  localparam int DRAIN_CYCLES = 20;

  // frame byte positions that a fault can hit
  localparam int NO_FAULT  = -1;
  localparam int POS_HDR2  = 1;
  localparam int POS_TAIL1 = 4;
  localparam int POS_TAIL2 = 5;

  logic clk;
  logic rst_n;
  bit   idle_on;
  bit   hold_req;
  bit   hold_active;
  int   err_cnt;

  // parser state as the bench sees it
  phase_e     parse_ph;
  logic [7:0] frame_cmd;
  logic [7:0] frame_data;

  // response words still owed by the block, oldest first
  out_item_t pending_rsp_q[$];

  sfh_in_if  cmd_if ();
  sfh_out_if rsp_if ();

  serial_command_frame_handler dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // owed words for one completed frame
  function automatic void act_on_frame(logic tx_idle);
    out_item_t  head;
    logic [7:0] rsp [6];
    logic [7:0] result;
    bit         respond;
    bit         single;
    head    = '0;
    result  = RESULT_FAIL;
    respond = 1'b0;
    single  = 1'b0;
    if (frame_cmd == CMD_LED) begin
      if (frame_data == DATA_OFF || frame_data == DATA_ON) begin
        head.led_write = 1'b1;
        head.led_on    = (frame_data == DATA_ON);
        result         = RESULT_OK;
      end
      respond = tx_idle;
      single  = !tx_idle && head.led_write;
    end else if (frame_cmd == CMD_BLINK) begin
      if (frame_data == DATA_OFF) begin
        head.blink_stop = 1'b1;
        head.led_write  = 1'b1;
        result          = RESULT_OK;
        respond         = tx_idle;
        single          = !tx_idle;
      end else begin
        head.blink_start   = 1'b1;
        head.blink_toggles = {frame_data, 1'b0};
        single             = 1'b1;
      end
    end
    if (respond) begin
      rsp = '{RSP_HDR1_BYTE, RSP_HDR2_BYTE, RSP_LEN_BYTE, result,
              RSP_TAIL1_BYTE, RSP_TAIL2_BYTE};
      // led and blink fields ride on the first word only
      for (int k = 0; k <= RSP_POS_TAIL2; k++) begin
        head.tx_valid = 1'b1;
        head.tx_byte  = rsp[k];
        head.last     = (k == RSP_POS_TAIL2);
        pending_rsp_q.push_back(head);
        head = '0;
      end
    end else if (single) begin
      head.last = 1'b1;
      pending_rsp_q.push_back(head);
    end
  endfunction

  // advance the parser by one accepted word
  function automatic void track_rx_byte(in_item_t w);
    if (w.running) begin
      case (parse_ph)
        PH_HDR1: begin
          if (w.rx_byte == HDR1_BYTE) parse_ph = PH_HDR2;
        end
        PH_HDR2: parse_ph = (w.rx_byte == HDR2_BYTE) ? PH_CMD : PH_HDR1;
        PH_CMD: begin
          frame_cmd = w.rx_byte;
          parse_ph  = PH_DATA;
        end
        PH_DATA: begin
          frame_data = w.rx_byte;
          parse_ph   = PH_TAIL1;
        end
        PH_TAIL1: parse_ph = (w.rx_byte == TAIL1_BYTE) ? PH_TAIL2 : PH_HDR1;
        PH_TAIL2: begin
          if (w.rx_byte == TAIL2_BYTE) act_on_frame(w.tx_idle);
          parse_ph = PH_HDR1;
        end
        default: parse_ph = PH_HDR1;
      endcase
    end
  endfunction

  function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  function automatic void compare_word(out_item_t want, out_item_t got);
    check_field("tx_valid", 9'(want.tx_valid), 9'(got.tx_valid));
    check_field("tx_byte", 9'(want.tx_byte), 9'(got.tx_byte));
    check_field("led_write", 9'(want.led_write), 9'(got.led_write));
    check_field("led_on", 9'(want.led_on), 9'(got.led_on));
    check_field("blink_start", 9'(want.blink_start), 9'(got.blink_start));
    check_field("blink_toggles", want.blink_toggles, got.blink_toggles);
    check_field("blink_stop", 9'(want.blink_stop), 9'(got.blink_stop));
    check_field("last", 9'(want.last), 9'(got.last));
  endfunction

  // input and output monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      // words already owed go out before a frame closing at this edge
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, rsp_if.data);
          err_cnt++;
        end else begin
          compare_word(pending_rsp_q.pop_front(), rsp_if.data);
        end
      end
      if (cmd_if.valid && cmd_if.ready) track_rx_byte(cmd_if.data);
    end
  end

  // long output hold-off on request
  initial begin
    forever begin
      wait (hold_req);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
      hold_req    = 1'b0;
    end
  end

  // output ready with random stall bursts
  initial begin
    int stall_left;
    rsp_if.ready = 1'b0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      rsp_if.ready <= !hold_active && (stall_left == 0);
    end
  end

  // offer one word, with an optional idle burst first
  task automatic push_rx_byte(logic [7:0] b, logic run, logic tx_idle);
    in_item_t w;
    int       gap;
    w.rx_byte = b;
    w.running = run;
    w.tx_idle = tx_idle;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
  endtask

  // one frame, optionally with a corrupted framing byte
  task automatic send_frame(logic [7:0] cmd, logic [7:0] dat, logic tx_idle, int bad_pos);
    logic [7:0] fb [6];
    fb = '{HDR1_BYTE, HDR2_BYTE, cmd, dat, TAIL1_BYTE, TAIL2_BYTE};
    if (bad_pos != NO_FAULT) fb[bad_pos] = fb[bad_pos] ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < 6; k++) begin
      // stray bytes while stopped must not disturb the frame
      if ($urandom_range(0, 15) == 0) push_rx_byte(8'($urandom), 1'b0, 1'($urandom));
      push_rx_byte(fb[k], 1'b1, (k == POS_TAIL2) ? tx_idle : 1'($urandom));
    end
  endtask

  task automatic test_led_command;
    send_frame(CMD_LED, DATA_ON, 1'b1, NO_FAULT);
    send_frame(CMD_LED, DATA_OFF, 1'b0, NO_FAULT);
    send_frame(CMD_LED, 8'hFF, 1'b1, NO_FAULT);
    send_frame(CMD_LED, 8'h02, 1'b0, NO_FAULT);
  endtask

  task automatic test_blink_command;
    send_frame(CMD_BLINK, 8'hFF, 1'b1, NO_FAULT);
    send_frame(CMD_BLINK, DATA_OFF, 1'b1, NO_FAULT);
    send_frame(CMD_BLINK, DATA_OFF, 1'b0, NO_FAULT);
  endtask

  task automatic test_other_command;
    send_frame(8'h00, DATA_ON, 1'b1, NO_FAULT);
  endtask

  task automatic test_framing_errors;
    logic [7:0] seq [7];
    // a repeated header byte is not a fresh frame start
    seq = '{HDR1_BYTE, HDR1_BYTE, HDR2_BYTE, CMD_LED, DATA_ON, TAIL1_BYTE, TAIL2_BYTE};
    foreach (seq[k]) push_rx_byte(seq[k], 1'b1, 1'b1);
    send_frame(CMD_LED, DATA_ON, 1'b1, POS_TAIL1);
    send_frame(CMD_LED, DATA_ON, 1'b1, POS_TAIL2);
  endtask

  task automatic test_ignored_when_stopped;
    // frame header while stopped, then one frame split by stopped bytes
    push_rx_byte(HDR1_BYTE, 1'b0, 1'b1);
    push_rx_byte(HDR2_BYTE, 1'b0, 1'b1);
    push_rx_byte(HDR1_BYTE, 1'b1, 1'b1);
    push_rx_byte(8'h00, 1'b0, 1'b1);
    push_rx_byte(HDR2_BYTE, 1'b1, 1'b1);
    push_rx_byte(CMD_BLINK, 1'b1, 1'b0);
    push_rx_byte(TAIL2_BYTE, 1'b0, 1'b0);
    push_rx_byte(DATA_ON, 1'b1, 1'b0);
    push_rx_byte(TAIL1_BYTE, 1'b1, 1'b0);
    push_rx_byte(TAIL2_BYTE, 1'b1, 1'b0);
  endtask

  // receiver stalls long while responses keep coming
  task automatic test_output_backpressure;
    hold_req = 1'b1;
    for (int k = 0; k < 5; k++) send_frame(CMD_LED, k[0] ? DATA_ON : DATA_OFF, 1'b1, NO_FAULT);
  endtask

  // mostly good frames with random content, plus broken frames and noise
  task automatic test_random_traffic(int n_words);
    int         sent;
    int         pick;
    int         n_noise;
    int         bad_pos;
    logic [7:0] cmd;
    logic [7:0] dat;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
        0, 1:    cmd = CMD_LED;
        2, 3:    cmd = CMD_BLINK;
        default: cmd = 8'($urandom);
      endcase
      case ($urandom_range(0, 2))
        0:       dat = DATA_OFF;
        1:       dat = DATA_ON;
        default: dat = 8'($urandom);
      endcase
      if (pick < 75) begin
        send_frame(cmd, dat, 1'($urandom), NO_FAULT);
        sent += 6;
      end else if (pick < 87) begin
        case ($urandom_range(0, 2))
          0:       bad_pos = POS_HDR2;
          1:       bad_pos = POS_TAIL1;
          default: bad_pos = POS_TAIL2;
        endcase
        send_frame(cmd, dat, 1'($urandom), bad_pos);
        sent += 6;
      end else if (pick < 95) begin
        n_noise = $urandom_range(1, 4);
        repeat (n_noise) push_rx_byte(8'($urandom), 1'b1, 1'($urandom));
        sent += n_noise;
      end else begin
        push_rx_byte(8'($urandom), 1'b0, 1'($urandom));
      end
    end
  endtask

  // test sequence
  initial begin
    rst_n        = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    idle_on      = 1'b1;
    parse_ph     = PH_HDR1;
    frame_cmd    = '0;
    frame_data   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_led_command();
    test_blink_command();
    test_other_command();
    test_framing_errors();
    test_ignored_when_stopped();
    test_output_backpressure();
    test_random_traffic(RANDOM_WORDS - CALM_WORDS);
    idle_on = 1'b0;
    test_random_traffic(CALM_WORDS);

    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_serial_command_frame_handler: done, clean");
    end else begin
      $display("tb_serial_command_frame_handler: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #5000000;
    $display("tb_serial_command_frame_handler: done, errors");
    $finish;
  end

endmodule

/* serial_command_frame_handler.f */
+incdir+rtl
rtl/sfh_pkg.sv
rtl/sfh_if.sv
rtl/serial_command_frame_handler.sv
bench/tb_serial_command_frame_handler.sv
